/* rtl/multi_voice_sample_mixer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_SAMPLE_MIXER_UNIT_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MVSM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MVSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mvsm_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer package
// Sizes, command codes, register indexes and the item types shared by the
// front end, the queue, the mixing engine and the top level.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  localparam int MAX_VOICES   = 8;
  localparam int BUFFER_WORDS = 65536;
  localparam int MAX_CHANNELS = 8;

  localparam int ADDR_W   = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam int VIDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int VCNT_W   = $clog2(MAX_VOICES + 1);
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 17;
  localparam int CH_W     = 3;
  localparam int CCNT_W   = 4;
  localparam int LADDR_W  = 16;
  // Frame position times channel count plus channel index.
  localparam int VADDR_W  = POS_W + CCNT_W + 1;
  // The stream sample plus one word per voice.
  localparam int ACC_W    = SAMPLE_W + VCNT_W;

  localparam logic [POS_W-1:0] POS_IDLE = '1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_BUFFER_FRAMES = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_VOICES_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    OP_MIX  = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LADDR_W-1:0]         load_addr;
    logic                       chunk;
    logic                       load_ok;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  buffer_frames;
    logic [CCNT_W-1:0] channel_count;
    logic [CCNT_W-1:0] voices_in_use;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       accepted;
  } result_t;

endpackage

/* rtl/mvsm_front.sv */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer front end
// Registers each input item and classifies it for the mixing engine.
// ----------------------------------------------------------------------------
module mvsm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic signed [mvsm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [mvsm_pkg::LADDR_W-1:0]         in_load_addr,
  input  logic                                 in_chunk,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mvsm_pkg::item_t                      out_item,
  output logic                                 busy
);

  logic            hold_valid;
  mvsm_pkg::item_t hold_item;
  mvsm_pkg::item_t item_next;

  assign in_ready = !hold_valid || out_ready;

  // Chunk start only matters on mix items; loads past the store are dropped.
  always_comb begin
    item_next.op        = mvsm_pkg::op_t'(in_cmd);
    item_next.sample    = in_sample;
    item_next.load_addr = in_load_addr;
    item_next.chunk     = in_chunk && (mvsm_pkg::op_t'(in_cmd) == mvsm_pkg::OP_MIX);
    item_next.load_ok   = 32'(in_load_addr) < 32'(mvsm_pkg::BUFFER_WORDS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= item_next;
    end
  end

  assign out_valid = hold_valid;
  assign out_item  = hold_item;
  assign busy      = hold_valid;

endmodule

/* rtl/mvsm_queue.sv */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer item queue
// Short FIFO of classified items between the front end and the engine.
// ----------------------------------------------------------------------------
module mvsm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mvsm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mvsm_pkg::item_t pop_item
);

  mvsm_pkg::item_t                 slots [mvsm_pkg::QDEPTH];
  logic [mvsm_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mvsm_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mvsm_pkg::QCNT_W-1:0]     count;
  logic                            push;
  logic                            pop;

  assign push_ready = count != mvsm_pkg::QCNT_W'(mvsm_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mvsm_pkg::QPTR_W'(mvsm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mvsm_pkg::QPTR_W'(mvsm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        2'b00,
        2'b11:   count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/mvsm_back.sv */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer engine
// Owns the sample store and the voice positions, runs one item at a time
// and visits one voice per cycle, then holds the result in an output register.
// ----------------------------------------------------------------------------
module mvsm_back (
  input  logic              clk,
  input  logic              rst,
  input  mvsm_pkg::cfg_t    cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  mvsm_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output mvsm_pkg::result_t res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_PLAY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                               state;
  logic [mvsm_pkg::POS_W-1:0]           pos [mvsm_pkg::MAX_VOICES];
  logic                                 stop_pending;
  logic                                 skip_chunk;
  logic [mvsm_pkg::CH_W-1:0]            ch_idx;
  logic [mvsm_pkg::VCNT_W-1:0]          vcnt;
  mvsm_pkg::op_t                        op;
  logic signed [mvsm_pkg::ACC_W-1:0]    acc;
  logic                                 accepted_r;
  logic                                 rd_flag;
  logic [mvsm_pkg::SAMPLE_W-1:0]        rdata;
  logic [mvsm_pkg::SAMPLE_W-1:0]        store [mvsm_pkg::BUFFER_WORDS];
  logic                                 res_valid_r;
  mvsm_pkg::result_t                    res_r;

  logic [mvsm_pkg::CCNT_W-1:0]          nc;
  logic [mvsm_pkg::VCNT_W-1:0]          nv;
  logic [mvsm_pkg::VIDX_W-1:0]          vidx;
  logic [mvsm_pkg::POS_W-1:0]           cur_pos;
  logic                                 active;
  logic [mvsm_pkg::VADDR_W-1:0]         vaddr;
  logic                                 in_range;
  logic [mvsm_pkg::ADDR_W-1:0]          raddr;
  logic                                 last_ch;
  logic                                 hi_ok;
  logic [mvsm_pkg::SAMPLE_W-1:0]        sat;
  logic                                 res_free;
  logic                                 take;

  // Out-of-range register values are clamped to the legal span.
  always_comb begin
    if (cfg.channel_count == '0) begin
      nc = mvsm_pkg::CCNT_W'(1);
    end else if (32'(cfg.channel_count) > mvsm_pkg::MAX_CHANNELS) begin
      nc = mvsm_pkg::CCNT_W'(mvsm_pkg::MAX_CHANNELS);
    end else begin
      nc = cfg.channel_count;
    end
    if (cfg.voices_in_use == '0) begin
      nv = mvsm_pkg::VCNT_W'(1);
    end else if (32'(cfg.voices_in_use) > mvsm_pkg::MAX_VOICES) begin
      nv = mvsm_pkg::VCNT_W'(mvsm_pkg::MAX_VOICES);
    end else begin
      nv = mvsm_pkg::VCNT_W'(cfg.voices_in_use);
    end
  end

  assign vidx     = vcnt[mvsm_pkg::VIDX_W-1:0];
  assign cur_pos  = pos[vidx];
  assign active   = cur_pos < cfg.buffer_frames;
  assign vaddr    = mvsm_pkg::VADDR_W'(cur_pos) * mvsm_pkg::VADDR_W'(nc)
                  + mvsm_pkg::VADDR_W'(ch_idx);
  assign in_range = 32'(vaddr) < 32'(mvsm_pkg::BUFFER_WORDS);
  assign raddr    = mvsm_pkg::ADDR_W'(vaddr);
  assign last_ch  = (mvsm_pkg::CCNT_W'(ch_idx) + 1'b1) >= nc;

  // The sum fits 16 bits when all bits above the sign agree with it.
  assign hi_ok = (&acc[mvsm_pkg::ACC_W-1:mvsm_pkg::SAMPLE_W-1])
              || !(|acc[mvsm_pkg::ACC_W-1:mvsm_pkg::SAMPLE_W-1]);
  assign sat   = hi_ok ? acc[mvsm_pkg::SAMPLE_W-1:0]
               : (acc[mvsm_pkg::ACC_W-1] ? 16'h8000 : 16'h7FFF);

  assign res_free   = !res_valid_r || res_ready;
  assign item_ready = state == S_IDLE;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stop_pending <= 1'b0;
      skip_chunk   <= 1'b0;
      ch_idx       <= '0;
      vcnt         <= '0;
      for (int v = 0; v < mvsm_pkg::MAX_VOICES; v++) begin
        pos[v] <= mvsm_pkg::POS_IDLE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op   <= item.op;
            vcnt <= '0;
            unique case (item.op)
              mvsm_pkg::OP_MIX: begin
                accepted_r <= 1'b0;
                if (item.chunk) begin
                  ch_idx <= '0;
                  if (stop_pending) begin
                    // The pending stop lands here and this chunk is not mixed.
                    for (int v = 0; v < mvsm_pkg::MAX_VOICES; v++) begin
                      pos[v] <= mvsm_pkg::POS_IDLE;
                    end
                    stop_pending <= 1'b0;
                    skip_chunk   <= 1'b1;
                    state        <= S_DONE;
                  end else begin
                    skip_chunk <= 1'b0;
                    state      <= S_MIX;
                  end
                end else begin
                  state <= skip_chunk ? S_DONE : S_MIX;
                end
              end
              mvsm_pkg::OP_PLAY: begin
                accepted_r <= 1'b0;
                state      <= stop_pending ? S_DONE : S_PLAY;
              end
              mvsm_pkg::OP_STOP: begin
                accepted_r   <= 1'b0;
                stop_pending <= 1'b1;
                state        <= S_DONE;
              end
              mvsm_pkg::OP_LOAD: begin
                accepted_r <= item.load_ok;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_MIX: begin
          // The word for the last voice lands while this state exits.
          if (vcnt == nv) begin
            state <= S_DONE;
          end else begin
            if (active && last_ch) begin
              pos[vidx] <= cur_pos + 1'b1;
            end
            vcnt <= vcnt + 1'b1;
          end
        end
        S_PLAY: begin
          if (vcnt == nv) begin
            state <= S_DONE;
          end else if (!active) begin
            pos[vidx]  <= '0;
            accepted_r <= 1'b1;
            state      <= S_DONE;
          end else begin
            vcnt <= vcnt + 1'b1;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_r.sample_out <= (op == mvsm_pkg::OP_MIX) ? $signed(sat) : '0;
            res_r.accepted   <= accepted_r;
            if (op == mvsm_pkg::OP_MIX) begin
              ch_idx <= last_ch ? '0 : ch_idx + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A read is issued for each active voice whose word lies inside the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_flag <= 1'b0;
    end else begin
      rd_flag <= (state == S_MIX) && (vcnt != nv) && active && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_r <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc <= mvsm_pkg::ACC_W'($signed(item.sample));
    end else if (rd_flag) begin
      acc <= acc + mvsm_pkg::ACC_W'($signed(rdata));
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.op == mvsm_pkg::OP_LOAD && item.load_ok) begin
      store[mvsm_pkg::ADDR_W'(item.load_addr)] <= item.sample;
    end
    rdata <= store[raddr];
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* rtl/multi_voice_sample_mixer_unit.sv */
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Polyphonic sample playback mixer with a loadable interleaved sample buffer.
// ----------------------------------------------------------------------------
// Each input item yields exactly one result. A mix item visits the voices in
// use (voices_in_use, clamped to 1..8) one after another, because the single
// read port of the sample memory serves one voice per cycle; a mix item inside
// a skipped chunk visits no voice. A play item visits no voice while a stop is
// pending and otherwise visits voices until it finds an idle one or has seen
// every voice in use; stop and load items visit no voice. A register stage and
// a two-entry queue sit in front of the mixing engine and an output register
// behind it, so input items keep being taken while a result waits, until the
// queue and the register stage are full. The sample memory is not cleared
// after reset; only words that have been loaded may be played. Write the
// configuration registers only while no item is in flight.
`include "multi_voice_sample_mixer_unit_defines.svh"

module multi_voice_sample_mixer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mvsm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] sample_in, [31:16] load_addr, [32] chunk_start, [39:33] zero
  input  logic [39:0]                    s_tdata,
  // [1:0] cmd
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] sample_out, [16] accepted, [23:17] zero
  output logic [23:0]                    m_tdata
);

  mvsm_pkg::cfg_t    cfg;
  logic              wr_en;
  logic              f_valid;
  logic              f_ready;
  mvsm_pkg::item_t   f_item;
  logic              f_busy;
  logic              q_valid;
  logic              q_ready;
  mvsm_pkg::item_t   q_item;
  mvsm_pkg::result_t res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_frames <= '0;
      cfg.channel_count <= mvsm_pkg::CCNT_W'(2);
      cfg.voices_in_use <= mvsm_pkg::CCNT_W'(8);
    end else if (wr_en) begin
      case (paddr[3:2])
        mvsm_pkg::REG_BUFFER_FRAMES: cfg.buffer_frames <= pwdata[mvsm_pkg::POS_W-1:0];
        mvsm_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[mvsm_pkg::CCNT_W-1:0];
        mvsm_pkg::REG_VOICES_IN_USE: cfg.voices_in_use <= pwdata[mvsm_pkg::CCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mvsm_pkg::REG_BUFFER_FRAMES: prdata = 32'(cfg.buffer_frames);
      mvsm_pkg::REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      mvsm_pkg::REG_VOICES_IN_USE: prdata = 32'(cfg.voices_in_use);
      default:                     prdata = '0;
    endcase
  end

  mvsm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_cmd       (s_tuser),
    .in_sample    ($signed(s_tdata[15:0])),
    .in_load_addr (s_tdata[31:16]),
    .in_chunk     (s_tdata[32]),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_item     (f_item),
    .busy         (f_busy)
  );

  mvsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  mvsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {7'b0, res.accepted, res.sample_out};

  `MVSM_ASSERT_NEXT(a_input_held, s_tvalid && s_tready, f_busy, "input transfer was not registered")
  `MVSM_ASSERT_NOW(a_accept_zero, m_tvalid && m_tdata[16], m_tdata[15:0] == 16'h0, "accepted result carries a sample")
  `MVSM_ASSERT_NOW(a_queue_fed, $rose(q_valid), $past(f_busy), "queue filled without a front item")

endmodule
